FILE: hw/rtl/pas_pkg.sv
// Package for the priority aging scheduler: table size, action codes,
// sequencer states and the priority clamp. No dependencies.
package pas_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);

  localparam logic signed [7:0] PRIO_HIGHEST = -8'sd20;
  localparam logic signed [7:0] PRIO_LOWEST  = 8'sd20;
  localparam logic signed [7:0] DYN_FLOOR    = -8'sd128;
  localparam logic [2:0]        AGING_RESET  = 3'd1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SETPRI = 2'd2,
    ACT_PICK   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // saturate a requested priority to the legal static range
  function automatic logic signed [5:0] clamp_prio(input logic signed [7:0] p);
    logic signed [7:0] c;
    begin
      if (p > PRIO_LOWEST) begin
        c = PRIO_LOWEST;
      end else if (p < PRIO_HIGHEST) begin
        c = PRIO_HIGHEST;
      end else begin
        c = p;
      end
      return c[5:0];
    end
  endfunction

endpackage

FILE: hw/rtl/priority_aging_scheduler.sv
// Priority scheduler with aging over a table of task slots.
// Depends on pas_pkg (table size, action codes, states, clamp).
//
// Usage: one transaction in, one transaction out. Add, remove and set-priority
// present their result the cycle after acceptance. A pick walks every slot once,
// one slot per cycle through a single shared compare and saturating-subtract
// unit, then in ST_FIN writes the winner's dynamic priority back to its static
// value and presents the result in ST_OUT. The input stalls from acceptance
// until the result transaction has been taken. Lower priority values are more
// urgent; among equal dynamic priorities the oldest insertion wins, then the
// lower slot. Every passed-over ready slot ages by aging_step, saturating at
// -128. The configuration register may only be written while the block is
// idle.
module priority_aging_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [3:0] in_slot,
  input  logic signed [7:0] in_prio,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_picked_valid,
  output logic [3:0] out_picked_slot,
  output logic       out_error,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_aging_step
);

  localparam int N = pas_pkg::MAX_TASKS;
  localparam int W = pas_pkg::IDX_W;

  // sequencer and scan state
  pas_pkg::state_t state_r, state_nxt;
  logic [W-1:0]    idx_r, idx_nxt;
  logic [W-1:0]    best_r, best_nxt;
  logic            best_found_r, best_found_nxt;
  logic signed [7:0] best_dyn_r, best_dyn_nxt;
  logic [7:0]      best_key_r, best_key_nxt;

  // result register
  logic            res_valid_r, res_valid_nxt;
  logic [3:0]      res_slot_r, res_slot_nxt;
  logic            res_err_r, res_err_nxt;

  // slot table
  logic [N-1:0]      ready_r, ready_nxt;
  logic signed [5:0] static_r [N];
  logic signed [7:0] dyn_r    [N];
  logic [7:0]        stamp_r  [N];
  logic [7:0]        stamp_cnt_r, stamp_cnt_nxt;
  logic [2:0]        aging_step_r;

  // table write controls
  logic              static_we;
  logic signed [5:0] static_wdata;
  logic              stamp_we;
  logic              dyn_we;
  logic [W-1:0]      dyn_waddr;
  logic signed [7:0] dyn_wdata;

  // decode of the incoming transaction
  pas_pkg::action_t  act;
  logic              slot_inside;
  logic [W-1:0]      slot_idx;
  logic              slot_ready;

  // shared scan unit
  logic              scan_ready;
  logic signed [7:0] scan_dyn;
  logic [7:0]        scan_key;
  logic signed [8:0] aged_wide;
  logic signed [7:0] aged;
  logic              scan_better;

  assign act         = pas_pkg::action_t'(in_action);
  assign slot_inside = 32'(in_slot) < 32'(N);
  assign slot_idx    = W'(in_slot);
  assign slot_ready  = slot_inside && ready_r[slot_idx];

  assign scan_ready  = ready_r[idx_r];
  assign scan_dyn    = dyn_r[idx_r];
  assign scan_key    = stamp_r[idx_r] - stamp_cnt_r;
  assign aged_wide   = 9'(scan_dyn) - $signed({6'b0, aging_step_r});
  assign aged        = (aged_wide < 9'(pas_pkg::DYN_FLOOR)) ? pas_pkg::DYN_FLOOR
                                                             : aged_wide[7:0];
  // strict compare keeps the oldest, then lowest-index, slot on ties
  assign scan_better = !best_found_r || (scan_dyn < best_dyn_r) ||
                       ((scan_dyn == best_dyn_r) && (scan_key < best_key_r));

  assign in_stall         = (state_r != pas_pkg::ST_IDLE);
  assign out_valid        = (state_r == pas_pkg::ST_OUT);
  assign out_picked_valid = res_valid_r;
  assign out_picked_slot  = res_slot_r;
  assign out_error        = res_err_r;
  assign cfg_ready        = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    best_found_nxt = best_found_r;
    best_dyn_nxt   = best_dyn_r;
    best_key_nxt   = best_key_r;
    res_valid_nxt  = res_valid_r;
    res_slot_nxt   = res_slot_r;
    res_err_nxt    = res_err_r;
    ready_nxt      = ready_r;
    stamp_cnt_nxt  = stamp_cnt_r;
    static_we      = 1'b0;
    static_wdata   = '0;
    stamp_we       = 1'b0;
    dyn_we         = 1'b0;
    dyn_waddr      = slot_idx;
    dyn_wdata      = '0;

    case (state_r)
      pas_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_valid_nxt = 1'b0;
          res_slot_nxt  = '0;
          res_err_nxt   = 1'b0;
          state_nxt     = pas_pkg::ST_OUT;
          case (act)
            pas_pkg::ACT_ADD: begin
              if (!slot_inside || slot_ready) begin
                res_err_nxt = 1'b1;
              end else begin
                ready_nxt[slot_idx] = 1'b1;
                static_we     = 1'b1;
                dyn_we        = 1'b1;
                stamp_we      = 1'b1;
                stamp_cnt_nxt = stamp_cnt_r + 8'd1;
              end
            end
            pas_pkg::ACT_REMOVE: begin
              if (!slot_ready) begin
                res_err_nxt = 1'b1;
              end else begin
                ready_nxt[slot_idx] = 1'b0;
              end
            end
            pas_pkg::ACT_SETPRI: begin
              if (!slot_ready) begin
                res_err_nxt = 1'b1;
              end else begin
                static_we    = 1'b1;
                static_wdata = pas_pkg::clamp_prio(in_prio);
                dyn_we       = 1'b1;
                dyn_wdata    = 8'(pas_pkg::clamp_prio(in_prio));
              end
            end
            pas_pkg::ACT_PICK: begin
              state_nxt      = pas_pkg::ST_SCAN;
              idx_nxt        = '0;
              best_found_nxt = 1'b0;
            end
            default: begin
              res_err_nxt = 1'b0;
            end
          endcase
        end
      end

      pas_pkg::ST_SCAN: begin
        // age every ready slot now; the winner is overwritten in ST_FIN
        if (scan_ready) begin
          dyn_we    = 1'b1;
          dyn_waddr = idx_r;
          dyn_wdata = aged;
          if (scan_better) begin
            best_nxt       = idx_r;
            best_found_nxt = 1'b1;
            best_dyn_nxt   = scan_dyn;
            best_key_nxt   = scan_key;
          end
        end
        if (idx_r == W'(N - 1)) begin
          state_nxt = pas_pkg::ST_FIN;
        end else begin
          idx_nxt = idx_r + W'(1);
        end
      end

      pas_pkg::ST_FIN: begin
        res_valid_nxt = best_found_r;
        res_slot_nxt  = best_found_r ? 4'(best_r) : 4'd0;
        res_err_nxt   = 1'b0;
        if (best_found_r) begin
          dyn_we    = 1'b1;
          dyn_waddr = best_r;
          dyn_wdata = 8'(static_r[best_r]);
        end
        state_nxt = pas_pkg::ST_OUT;
      end

      pas_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = pas_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pas_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pas_pkg::ST_IDLE;
      idx_r        <= '0;
      best_found_r <= 1'b0;
      ready_r      <= '0;
      stamp_cnt_r  <= '0;
      aging_step_r <= pas_pkg::AGING_RESET;
      res_valid_r  <= 1'b0;
      res_slot_r   <= '0;
      res_err_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      best_found_r <= best_found_nxt;
      ready_r      <= ready_nxt;
      stamp_cnt_r  <= stamp_cnt_nxt;
      res_valid_r  <= res_valid_nxt;
      res_slot_r   <= res_slot_nxt;
      res_err_r    <= res_err_nxt;
      if (cfg_valid && cfg_ready) begin
        aging_step_r <= cfg_aging_step;
      end
    end
  end

  // payload: scan bests and the slot table
  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    best_dyn_r <= best_dyn_nxt;
    best_key_r <= best_key_nxt;
    if (static_we) begin
      static_r[slot_idx] <= static_wdata;
    end
    if (stamp_we) begin
      stamp_r[slot_idx] <= stamp_cnt_r;
    end
    if (dyn_we) begin
      dyn_r[dyn_waddr] <= dyn_wdata;
    end
  end

endmodule

FILE: hw/rtl/pas_checker.sv
// Port-level checks for priority_aging_scheduler, bound into that module.
// Depends on pas_pkg for the action codes.
module pas_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_picked_valid,
  input logic [3:0] out_picked_slot,
  input logic       out_error
);

  // a held result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable(out_picked_valid) && $stable(out_picked_slot) && $stable(out_error))
    else $error("result changed while stalled");

  // a successful pick never reports an error
  a_pick_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_picked_valid |-> !out_error)
    else $error("pick result flagged error");

  // no pick, no slot
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_picked_valid |-> out_picked_slot == 4'd0)
    else $error("slot nonzero without pick");

  // table updates answer on the next cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action != pas_pkg::ACT_PICK) |=>
      out_valid && !out_picked_valid)
    else $error("non-pick transaction did not answer next cycle");

  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

endmodule

bind priority_aging_scheduler pas_checker u_pas_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_picked_valid (out_picked_valid),
  .out_picked_slot  (out_picked_slot),
  .out_error        (out_error)
);
